[design/npis_pkg.sv]
`default_nettype none

package npis_pkg;

   // Default sizes of the point table and the coordinates
   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;

   // Fixed field widths of the channels
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   // Request kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

[design/nearest_point_index_search.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_kind, req_point_index, req_x_coord, req_y_coord
// rsp       out        rsp_valid/rsp_ready  rsp_nearest_index
// csr       in         csr_valid/csr_ready  csr_active_points
//
// A write transfer produces no response.
// A query reads one table entry per cycle from the point RAM; each entry passes
// through the RAM read port and the distance pipeline (p0 to p2) before the
// response is presented; an empty scan goes straight to the reply.
// Requests are taken only between queries; the response register holds a
// finished result while a new request is taken and a scan runs.
// Synchronous reset clears the control state; the table is not cleared.

module nearest_point_index_search #(
   parameter int MAX_POINTS = npis_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = npis_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic [npis_pkg::INDEX_W-1:0]  req_point_index,
   input  wire logic signed [COORD_BITS-1:0]  req_x_coord,
   input  wire logic signed [COORD_BITS-1:0]  req_y_coord,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [npis_pkg::INDEX_W-1:0]  rsp_nearest_index,

   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [npis_pkg::COUNT_W-1:0]  csr_active_points
);

   import npis_pkg::*;

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CB    = COORD_BITS;
   localparam int SQ_W  = 2 * CB;
   localparam int D_W   = 2 * CB + 1;
   localparam int LW_P  = $clog2(MAX_POINTS + 1);
   localparam int LW    = (LW_P > COUNT_W) ? LW_P : COUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] active_ff, active_in;

   logic signed [CB-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;

   // pipeline: p0 = RAM output, p1 = abs differences, p2 = squares
   logic          p0_valid_ff, p0_last_ff;
   logic [AW-1:0] p0_idx_ff;
   logic          p1_valid_ff, p1_last_ff;
   logic [AW-1:0] p1_idx_ff;
   logic [CB-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic          p2_valid_ff, p2_last_ff;
   logic [AW-1:0] p2_idx_ff;
   logic [SQ_W-1:0] sqx_ff, sqy_ff;

   logic [D_W-1:0] best_dist_ff, best_dist_in;
   logic [AW-1:0]  best_idx_ff, best_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic req_xfer, rsp_xfer;
   logic [LW-1:0] limit;
   logic          scan_last;

   logic [AW+INDEX_W-1:0] wr_idx_ext;
   logic                  wr_in_range;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic                  ram_rd_en;
   logic [2*CB-1:0]       ram_rd_data;
   logic signed [CB-1:0]  px, py;
   logic signed [CB:0]    diff_x, diff_y;
   logic [D_W-1:0]        sum_dist;
   logic [AW+INDEX_W-1:0] best_idx_ext;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // scan length saturates at the table depth
   assign limit = (LW'(active_ff) > LW'(MAX_POINTS)) ? LW'(MAX_POINTS) : LW'(active_ff);
   assign scan_last = ((LW + 1)'(rd_idx_ff) + (LW + 1)'(1)) == (LW + 1)'(limit);

   assign wr_idx_ext  = (AW + INDEX_W)'(req_point_index);
   assign wr_in_range = (32'(req_point_index) < 32'(MAX_POINTS));
   assign ram_wr_en   = req_xfer && (req_kind == KIND_WRITE) && wr_in_range;
   assign ram_wr_addr = wr_idx_ext[AW-1:0];
   assign ram_rd_en   = (state_ff == ST_SCAN);

   npis_ram #(
      .WIDTH(2 * CB),
      .DEPTH(MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_x_coord, req_y_coord}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign px = ram_rd_data[2*CB-1:CB];
   assign py = ram_rd_data[CB-1:0];

   always_comb begin
      diff_x = (CB + 1)'(qx_ff) - (CB + 1)'(px);
      diff_y = (CB + 1)'(qy_ff) - (CB + 1)'(py);
      dx_in  = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
      dy_in  = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];
   end

   assign sum_dist = D_W'(sqx_ff) + D_W'(sqy_ff);

   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (p2_valid_ff) begin
         // first entry always taken; later ones only when strictly closer
         if ((p2_idx_ff == '0) || (sum_dist < best_dist_ff)) begin
            best_dist_in = sum_dist;
            best_idx_in  = p2_idx_ff;
         end
      end
      if ((state_ff == ST_IDLE) && req_xfer && (req_kind == KIND_QUERY) &&
          (limit == '0)) begin
         best_idx_in = '0;
      end
   end

   assign best_idx_ext = (AW + INDEX_W)'(best_idx_ff);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_index_in = rsp_index_ff;

      if (csr_valid && csr_ready) begin
         active_in = csr_active_points;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_kind == KIND_QUERY)) begin
               qx_in     = req_x_coord;
               qy_in     = req_y_coord;
               rd_idx_in = '0;
               state_in  = (limit == '0) ? ST_REPLY : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + AW'(1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (p2_valid_ff && p2_last_ff) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = best_idx_ext[INDEX_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         p0_valid_ff  <= ram_rd_en;
         p1_valid_ff  <= p0_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_index_ff <= rsp_index_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      p0_last_ff   <= ram_rd_en && scan_last;
      p0_idx_ff    <= rd_idx_ff;
      p1_last_ff   <= p0_last_ff;
      p1_idx_ff    <= p0_idx_ff;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      p2_last_ff   <= p1_last_ff;
      p2_idx_ff    <= p1_idx_ff;
      sqx_ff       <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff       <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;

endmodule

`default_nettype wire

[design/npis_ram.sv]
`default_nettype none

module npis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/npis_checker.sv]
`default_nettype none

module npis_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_kind,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [npis_pkg::INDEX_W-1:0] rsp_nearest_index
);

   import npis_pkg::*;

   logic       query_xfer, rsp_xfer;
   logic [1:0] open_ff, open_in;

   assign query_xfer = req_valid && req_ready && (req_kind == KIND_QUERY);
   assign rsp_xfer   = rsp_valid && rsp_ready;

   // queries taken minus responses delivered
   always_comb begin
      open_in = open_ff;
      if (query_xfer && !rsp_xfer) begin
         open_in = open_ff + 2'd1;
      end else if (!query_xfer && rsp_xfer) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_index))
      else $error("response dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response presented right after reset");

   a_rsp_has_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 2'd0))
      else $error("response without an outstanding query");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> !req_ready)
      else $error("request taken in the cycle after a query");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two queries outstanding");

endmodule

bind nearest_point_index_search npis_checker u_npis_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_kind          (req_kind),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_nearest_index (rsp_nearest_index)
);

`default_nettype wire
